>>> hdl/route_step_sequencer_defines.svh
`ifndef ROUTE_STEP_SEQUENCER_DEFINES_SVH
`define ROUTE_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define RSS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route_step_sequencer: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted
`define RSS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route_step_sequencer: next-cycle check failed");

`endif

>>> hdl/rss_pkg.sv
package rss_pkg;

  // Field widths of the item channels
  localparam int CMD_W      = 2;
  localparam int SEL_SEQ_W  = 3;
  localparam int SEL_STEP_W = 5;
  localparam int OP_W       = 4;
  localparam int BASE_W     = 12;
  localparam int TARGET_W   = 24;
  localparam int ENC_W      = 24;
  localparam int GAIN_W     = 13;
  localparam int DRV_W      = 13;
  localparam int COUNT_W    = 4;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Commands carried in the input tuser
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd3;

  // Step opcodes; anything else is a stop
  localparam logic [OP_W-1:0] OP_FWD   = 4'd1;
  localparam logic [OP_W-1:0] OP_LEFT  = 4'd2;
  localparam logic [OP_W-1:0] OP_RIGHT = 4'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN = 2'd2;

  // Configuration reset values
  localparam logic [COUNT_W-1:0] SEQ_COUNT_RST  = 4'd5;
  localparam logic [GAIN_W-1:0]  LEFT_GAIN_RST  = 13'd4207;
  localparam logic [GAIN_W-1:0]  RIGHT_GAIN_RST = 13'd3994;

  // One stored route step
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [BASE_W-1:0]   drive;
    logic [OP_W-1:0]     op;
  } step_entry_t;

  function automatic logic is_motion(input logic [OP_W-1:0] op);
    is_motion = (op == OP_FWD) || (op == OP_LEFT) || (op == OP_RIGHT);
  endfunction

endpackage

>>> hdl/rss_step_mem.sv
module rss_step_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  rss_pkg::step_entry_t wr_data,
  input  logic [ADDR_W-1:0]   rd_addr_a,
  input  logic [ADDR_W-1:0]   rd_addr_b,
  output rss_pkg::step_entry_t rd_data_a,
  output rss_pkg::step_entry_t rd_data_b
);
  import rss_pkg::*;

  step_entry_t step_mem [DEPTH];
  step_entry_t rd_a_r;
  step_entry_t rd_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      step_mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports, write data forwarded on an address match
  always_ff @(posedge clk) begin
    rd_a_r <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : step_mem[rd_addr_a];
    rd_b_r <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : step_mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> hdl/rss_scale.sv
module rss_scale (
  input  logic [rss_pkg::BASE_W-1:0] base,
  input  logic [rss_pkg::GAIN_W-1:0] gain,
  output logic [rss_pkg::DRV_W-1:0]  mag
);
  import rss_pkg::*;

  localparam int PROD_W = BASE_W + GAIN_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] lo_bound;
  logic [PROD_W-1:0] hi_bound;
  logic [PROD_W-1:0] clamped;
  logic [PROD_W:0]   rounded;

  // Q.12 product and its bounds at 0.5 and 1.5 times the base
  assign prod     = PROD_W'(base) * PROD_W'(gain);
  assign lo_bound = PROD_W'({base, 11'b0});
  assign hi_bound = PROD_W'({base, 12'b0}) + PROD_W'({base, 11'b0});

  always_comb begin
    priority if (prod < lo_bound) begin
      clamped = lo_bound;
    end else if (prod > hi_bound) begin
      clamped = hi_bound;
    end else begin
      clamped = prod;
    end
  end

  // Round half up on the magnitude, drop the fraction
  assign rounded = (PROD_W + 1)'(clamped) + (PROD_W + 1)'(2048);
  assign mag     = rounded[12 +: DRV_W];

endmodule

>>> hdl/route_step_sequencer.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_tvalid/in_tready | tuser command, tdata load and encoder fields
// out_    | output    | out_tvalid/out_tready | tdata drives, flags, sequence and step
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// An item passes an input register and a result register; the result is
// registered as the item leaves the input register, one item accepted per
// cycle when out_tready is high.
// The step table answers two registered reads (current and next step) that
// track the sequence and step registers, so a tick finds both steps ready.
// Reset (rst_n low, synchronous) clears control state and loads config
// defaults; the step table is not cleared. A held result stalls the input
// register, and in_tready drops once it is full.
module route_step_sequencer #(
  parameter int MAX_SEQUENCES = 8,
  parameter int MAX_STEPS     = 32,
  parameter int DRIVE_LIMIT   = 3600
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seq_sel, step_sel, step_op, step_drive, step_target, enc_m1..enc_m4
  input  logic [rss_pkg::IN_DATA_W-1:0]    in_tdata,
  // command
  input  logic [rss_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drive_m1..drive_m4, brake, clear_counts, running, active_sequence,
  // active_step, one pad bit
  output logic [rss_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rss_pkg::*;

  `include "route_step_sequencer_defines.svh"

  localparam int DEPTH  = MAX_SEQUENCES * MAX_STEPS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SEQ_W  = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int STEP_W = $clog2(MAX_STEPS);
  localparam int CNT_W  = $clog2(MAX_SEQUENCES + 1);
  localparam logic [15:0] DRIVE_LIM = 16'(DRIVE_LIMIT);

  // Configuration registers
  logic [COUNT_W-1:0] seq_count_r;
  logic [GAIN_W-1:0]  left_gain_r;
  logic [GAIN_W-1:0]  right_gain_r;

  // Input register
  logic                 s1_valid_r;
  logic [CMD_W-1:0]     s1_cmd_r;
  logic [IN_DATA_W-1:0] s1_data_r;

  // Sequencer state
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic [DRV_W-1:0]  drive_r [4];
  logic [DRV_W-1:0]  drive_nxt [4];
  logic              brake_nxt, clear_nxt;

  // Result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic adv;
  logic drives_zero;
  logic idle_tick;

  // Unpacked input fields
  logic [SEL_SEQ_W-1:0]  s1_seq_sel;
  logic [SEL_STEP_W-1:0] s1_step_sel;
  logic [OP_W-1:0]       s1_op;
  logic [BASE_W-1:0]     s1_base;
  logic [TARGET_W-1:0]   s1_target;
  logic [ENC_W-1:0]      s1_enc [4];

  // Table access
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  step_entry_t       wr_data;
  logic [ADDR_W-1:0] rd_addr_cur, rd_addr_nxt;
  step_entry_t       cur_step, nxt_step;
  logic              load_ok;

  // Tick datapath
  logic [DRV_W-1:0]  l_mag, r_mag;
  logic [DRV_W-1:0]  l_drv, r_drv;
  logic              l_ok, r_ok;
  logic              reached;
  logic              last_cur, last_nxt;
  logic              run_ends;
  logic [ENC_W-1:0]  enc_mag [4];

  // Sequence wrap
  logic [SEQ_W-1:0]  wrap_tbl [MAX_SEQUENCES+1][MAX_SEQUENCES+1];
  logic [CNT_W-1:0]  seq_inc;
  logic [CNT_W-1:0]  seq_lim;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_count_r  <= SEQ_COUNT_RST;
      left_gain_r  <= LEFT_GAIN_RST;
      right_gain_r <= RIGHT_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEQ_COUNT:  seq_count_r  <= cfg_data[COUNT_W-1:0];
        CFG_LEFT_GAIN:  left_gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_RIGHT_GAIN: right_gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance the input register when the result register is free or being taken
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  assign s1_seq_sel  = s1_data_r[2:0];
  assign s1_step_sel = s1_data_r[7:3];
  assign s1_op       = s1_data_r[11:8];
  assign s1_base     = s1_data_r[23:12];
  assign s1_target   = s1_data_r[47:24];
  assign s1_enc[0]   = s1_data_r[71:48];
  assign s1_enc[1]   = s1_data_r[95:72];
  assign s1_enc[2]   = s1_data_r[119:96];
  assign s1_enc[3]   = s1_data_r[143:120];

  // Wrap table for (sequence + 1) modulo the active count
  for (genvar ga = 0; ga <= MAX_SEQUENCES; ga++) begin : g_wrap_a
    for (genvar gn = 0; gn <= MAX_SEQUENCES; gn++) begin : g_wrap_n
      if (gn == 0) begin : g_zero
        assign wrap_tbl[ga][gn] = '0;
      end else begin : g_mod
        localparam int WRAP = ga % gn;
        assign wrap_tbl[ga][gn] = SEQ_W'(WRAP);
      end
    end
  end

  assign seq_inc = CNT_W'(seq_r) + CNT_W'(1);

  // Clamp the sequence count into one to the table size
  always_comb begin
    priority if (seq_count_r == '0) begin
      seq_lim = CNT_W'(1);
    end else if (32'(seq_count_r) > MAX_SEQUENCES) begin
      seq_lim = CNT_W'(MAX_SEQUENCES);
    end else begin
      seq_lim = CNT_W'(seq_count_r);
    end
  end

  // Table load
  assign load_ok = (32'(s1_seq_sel) < MAX_SEQUENCES) && (32'(s1_step_sel) < MAX_STEPS);
  assign wr_addr = ADDR_W'(32'(s1_seq_sel) * MAX_STEPS + 32'(s1_step_sel));
  assign wr_data = '{target: s1_target, drive: s1_base, op: s1_op};

  // Read current and following step at the state the next item will see
  assign last_nxt    = (32'(step_nxt) == MAX_STEPS - 1);
  assign rd_addr_cur = ADDR_W'(32'(seq_nxt) * MAX_STEPS + 32'(step_nxt));
  assign rd_addr_nxt = last_nxt ? rd_addr_cur : rd_addr_cur + ADDR_W'(1);

  rss_step_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_step_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_cur),
    .rd_addr_b (rd_addr_nxt),
    .rd_data_a (cur_step),
    .rd_data_b (nxt_step)
  );

  // Per-side scaled drive magnitudes
  rss_scale u_scale_left (
    .base (cur_step.drive),
    .gain (left_gain_r),
    .mag  (l_mag)
  );

  rss_scale u_scale_right (
    .base (cur_step.drive),
    .gain (right_gain_r),
    .mag  (r_mag)
  );

  // Right turn reverses the left side, left turn the right side
  assign l_drv = (cur_step.op == OP_RIGHT) ? -l_mag : l_mag;
  assign r_drv = (cur_step.op == OP_LEFT)  ? -r_mag : r_mag;
  assign l_ok  = 16'(l_mag) <= DRIVE_LIM;
  assign r_ok  = 16'(r_mag) <= DRIVE_LIM;

  // Step completion on any wheel count magnitude reaching a nonzero target
  always_comb begin
    reached = 1'b0;
    for (int i = 0; i < 4; i++) begin
      enc_mag[i] = s1_enc[i][ENC_W-1] ? -s1_enc[i] : s1_enc[i];
      if ((cur_step.target != '0) && (enc_mag[i] >= cur_step.target)) begin
        reached = 1'b1;
      end
    end
  end

  assign last_cur = (32'(step_r) == MAX_STEPS - 1);
  assign run_ends = last_cur || !is_motion(nxt_step.op);

  // Item processing
  always_comb begin
    seq_nxt   = seq_r;
    step_nxt  = step_r;
    run_nxt   = run_r;
    brake_nxt = 1'b0;
    clear_nxt = 1'b0;
    wr_en     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      drive_nxt[i] = drive_r[i];
    end
    if (adv) begin
      unique case (s1_cmd_r)
        CMD_LOAD: begin
          wr_en = load_ok;
        end
        CMD_NEXT: begin
          seq_nxt  = wrap_tbl[seq_inc][seq_lim];
          step_nxt = '0;
          run_nxt  = 1'b0;
          for (int i = 0; i < 4; i++) drive_nxt[i] = '0;
        end
        CMD_START: begin
          if (!run_r) begin
            run_nxt  = 1'b1;
            step_nxt = '0;
            for (int i = 0; i < 4; i++) drive_nxt[i] = '0;
          end
        end
        CMD_TICK: begin
          if (run_r) begin
            if (!is_motion(cur_step.op)) begin
              // Stop step: brake and end the run
              for (int i = 0; i < 4; i++) drive_nxt[i] = '0;
              brake_nxt = 1'b1;
              run_nxt   = 1'b0;
            end else begin
              // Apply drives within the limit, keep the old value otherwise
              if (l_ok) begin
                drive_nxt[0] = l_drv;
                drive_nxt[1] = l_drv;
              end
              if (r_ok) begin
                drive_nxt[2] = r_drv;
                drive_nxt[3] = r_drv;
              end
              if (reached) begin
                for (int i = 0; i < 4; i++) drive_nxt[i] = '0;
                brake_nxt = 1'b1;
                clear_nxt = 1'b1;
                if (run_ends) begin
                  run_nxt = 1'b0;
                end else begin
                  step_nxt = step_r + STEP_W'(1);
                end
              end
            end
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      step_r <= '0;
      run_r  <= 1'b0;
      for (int i = 0; i < 4; i++) drive_r[i] <= '0;
    end else begin
      seq_r  <= seq_nxt;
      step_r <= step_nxt;
      run_r  <= run_nxt;
      for (int i = 0; i < 4; i++) drive_r[i] <= drive_nxt[i];
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {1'b0, SEL_STEP_W'(step_nxt), SEL_SEQ_W'(seq_nxt), run_nxt,
                     clear_nxt, brake_nxt,
                     drive_nxt[3], drive_nxt[2], drive_nxt[1], drive_nxt[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign drives_zero = (drive_r[0] == '0) && (drive_r[1] == '0) &&
                       (drive_r[2] == '0) && (drive_r[3] == '0);
  assign idle_tick   = adv && (s1_cmd_r == CMD_TICK) && !run_r;

  // Drives are zero whenever no run is active
  `RSS_ASSERT_NOW(a_idle_drives_zero, !run_r, drives_zero)
  // A tick while idle leaves the position unchanged
  `RSS_ASSERT_NEXT(a_idle_tick_holds, idle_tick, $stable(seq_r) && $stable(step_r) && !run_r)
  // The selected sequence always lies inside the table
  `RSS_ASSERT_NOW(a_seq_in_range, s1_valid_r || !s1_valid_r, 32'(seq_r) < MAX_SEQUENCES)

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam int MAX_SEQ      = 8;
  localparam int MAX_STEP     = 32;
  localparam int DRIVE_MAX    = 3600;
  localparam int FULL_MAG     = 8388608;
  localparam int LIMIT_CYCLES = 300000;

  // Input tdata layout, first field in the lowest bits
  typedef struct packed {
    logic [3:0][ENC_W-1:0] enc;
    logic [TARGET_W-1:0]   step_target;
    logic [BASE_W-1:0]     step_drive;
    logic [OP_W-1:0]       step_op;
    logic [SEL_STEP_W-1:0] step_sel;
    logic [SEL_SEQ_W-1:0]  seq_sel;
  } route_item_t;

  // Output tdata layout below the pad bit
  typedef struct packed {
    logic [SEL_STEP_W-1:0] active_step;
    logic [SEL_SEQ_W-1:0]  active_sequence;
    logic                  running;
    logic                  clear_counts;
    logic                  brake;
    logic [3:0][DRV_W-1:0] drive;
  } route_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = CMD_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SEQ_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted sequencer state and registers
  logic [OP_W-1:0]     tbl_op     [MAX_SEQ][MAX_STEP];
  logic [BASE_W-1:0]   tbl_drive  [MAX_SEQ][MAX_STEP];
  logic [TARGET_W-1:0] tbl_target [MAX_SEQ][MAX_STEP];
  bit                  tbl_loaded [MAX_SEQ][MAX_STEP];
  int                  cur_seq = 0;
  int                  cur_step = 0;
  bit                  run_on = 1'b0;
  int                  drv [4] = '{0, 0, 0, 0};
  int                  cfg_count = SEQ_COUNT_RST;
  int                  cfg_lgain = LEFT_GAIN_RST;
  int                  cfg_rgain = RIGHT_GAIN_RST;

  route_result_t expected_outputs [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int routes_run = 0;
  int settings_applied = 0;
  int mismatches = 0;
  int cycle_count = 0;

  route_step_sequencer #(
    .MAX_SEQUENCES(MAX_SEQ),
    .MAX_STEPS    (MAX_STEP),
    .DRIVE_LIMIT  (DRIVE_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit moving_op(input logic [OP_W-1:0] op);
    return op == OP_FWD || op == OP_LEFT || op == OP_RIGHT;
  endfunction

  // Q.12 gain, clamped to half and one-and-a-half times base, rounded
  function automatic int scaled_drive(input int unsigned base, input int unsigned gain);
    int unsigned p, lo, hi;
    p  = base * gain;
    lo = base * 2048;
    hi = base * 6144;
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    return int'((p + 2048) >> 12);
  endfunction

  function automatic route_item_t random_item();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return route_item_t'(raw[IN_DATA_W-1:0]);
  endfunction

  // Wheel count with a magnitude in [lo, hi], random sign
  function automatic logic [ENC_W-1:0] count_in(input int lo, input int hi);
    int m;
    if (hi > FULL_MAG) hi = FULL_MAG;
    m = $urandom_range(hi, lo);
    if (m == FULL_MAG || (m != 0 && $urandom_range(1) == 1)) return ENC_W'(-m);
    return ENC_W'(m);
  endfunction

  // Advance the predicted state by one accepted item and queue its result
  task automatic advance_sequencer(input logic [CMD_W-1:0] cmd, input route_item_t it);
    route_result_t r;
    logic [OP_W-1:0] op;
    bit brake_now, clear_now, reached, ends;
    int l, rt, sl, sr, c, mag, tgt, n;
    brake_now = 1'b0;
    clear_now = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        tbl_op[it.seq_sel][it.step_sel]     = it.step_op;
        tbl_drive[it.seq_sel][it.step_sel]  = it.step_drive;
        tbl_target[it.seq_sel][it.step_sel] = it.step_target;
        tbl_loaded[it.seq_sel][it.step_sel] = 1'b1;
      end
      CMD_NEXT: begin
        n = cfg_count;
        if (n < 1) n = 1;
        if (n > MAX_SEQ) n = MAX_SEQ;
        cur_seq  = (cur_seq + 1) % n;
        cur_step = 0;
        run_on   = 1'b0;
        drv      = '{0, 0, 0, 0};
      end
      CMD_START: begin
        if (!run_on) begin
          drv      = '{0, 0, 0, 0};
          run_on   = 1'b1;
          cur_step = 0;
        end
      end
      default: begin
        if (run_on) begin
          op = tbl_op[cur_seq][cur_step];
          if (!moving_op(op)) begin
            drv       = '{0, 0, 0, 0};
            brake_now = 1'b1;
            run_on    = 1'b0;
          end else begin
            l  = scaled_drive(tbl_drive[cur_seq][cur_step], cfg_lgain);
            rt = scaled_drive(tbl_drive[cur_seq][cur_step], cfg_rgain);
            sl = (op == OP_RIGHT) ? -l : l;
            sr = (op == OP_LEFT) ? -rt : rt;
            // hold the old drive where the new one is over the limit
            if (sl >= -DRIVE_MAX && sl <= DRIVE_MAX) begin
              drv[0] = sl;
              drv[1] = sl;
            end
            if (sr >= -DRIVE_MAX && sr <= DRIVE_MAX) begin
              drv[2] = sr;
              drv[3] = sr;
            end
            tgt     = tbl_target[cur_seq][cur_step];
            reached = 1'b0;
            if (tgt > 0) begin
              for (int i = 0; i < 4; i++) begin
                c   = int'($signed(it.enc[i]));
                mag = (c < 0) ? -c : c;
                if (mag >= tgt) reached = 1'b1;
              end
            end
            // finish the step: advance, or end at a stop or the table end
            if (reached) begin
              ends = 1'b1;
              if (cur_step + 1 < MAX_STEP) ends = !moving_op(tbl_op[cur_seq][cur_step + 1]);
              drv       = '{0, 0, 0, 0};
              brake_now = 1'b1;
              clear_now = 1'b1;
              if (ends) run_on = 1'b0;
              else cur_step = cur_step + 1;
            end
          end
        end
      end
    endcase
    for (int i = 0; i < 4; i++) r.drive[i] = DRV_W'(drv[i]);
    r.brake           = brake_now;
    r.clear_counts    = clear_now;
    r.running         = run_on;
    r.active_sequence = SEL_SEQ_W'(cur_seq);
    r.active_step     = SEL_STEP_W'(cur_step);
    expected_outputs.push_back(r);
  endtask

  // Offer one item after a random idle gap and predict it once accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input route_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    advance_sequencer(cmd, it);
    items_sent++;
  endtask

  task automatic send_load(input int s, input int t, input logic [OP_W-1:0] op,
                           input logic [BASE_W-1:0] base, input logic [TARGET_W-1:0] aim);
    route_item_t it;
    it             = random_item();
    it.seq_sel     = SEL_SEQ_W'(s);
    it.step_sel    = SEL_STEP_W'(t);
    it.step_op     = op;
    it.step_drive  = base;
    it.step_target = aim;
    send_item(CMD_LOAD, it);
  endtask

  task automatic send_key(input logic [CMD_W-1:0] cmd);
    send_item(cmd, random_item());
  endtask

  task automatic fill_entry(input int s, input int t);
    if (!tbl_loaded[s][t])
      send_load(s, t, OP_W'($urandom_range(15)), BASE_W'($urandom), TARGET_W'($urandom));
  endtask

  // Load the current and following step before a tick can read them
  task automatic cover_steps();
    if (run_on) begin
      fill_entry(cur_seq, cur_step);
      if (cur_step + 1 < MAX_STEP) fill_entry(cur_seq, cur_step + 1);
    end
  endtask

  task automatic send_tick(input logic [3:0][ENC_W-1:0] counts);
    route_item_t it;
    cover_steps();
    it     = random_item();
    it.enc = counts;
    send_item(CMD_TICK, it);
  endtask

  // Tick with counts below the current target, or with one wheel at or above it
  task automatic route_tick(input bit reach);
    logic [3:0][ENC_W-1:0] counts;
    int tgt, hi;
    cover_steps();
    tgt = run_on ? int'(tbl_target[cur_seq][cur_step]) : 0;
    hi  = (tgt == 0) ? FULL_MAG : ((tgt - 1 < FULL_MAG) ? tgt - 1 : FULL_MAG);
    for (int i = 0; i < 4; i++) counts[i] = count_in(0, hi);
    if (reach && tgt != 0 && tgt <= FULL_MAG) counts[$urandom_range(3)] = count_in(tgt, FULL_MAG);
    send_tick(counts);
  endtask

  // Load a route into the selected sequence, start it and drive it to its end
  task automatic run_route(input int len, input bit quick);
    logic [OP_W-1:0] op;
    logic [BASE_W-1:0] base;
    logic [TARGET_W-1:0] aim;
    int tgt, stuck, v;
    routes_run++;
    for (int s = 0; s < len; s++) begin
      op   = OP_W'($urandom_range(3, 1));
      base = ($urandom_range(5) == 0) ? BASE_W'($urandom_range(4095, 3000))
                                      : BASE_W'($urandom_range(3000));
      case ($urandom_range(9))
        0:       aim = quick ? TARGET_W'(1) : TARGET_W'(0);
        1:       aim = quick ? TARGET_W'(1) : TARGET_W'($urandom_range(24'hFFFFFF, 1));
        2:       aim = TARGET_W'($urandom_range(FULL_MAG, 1));
        default: aim = TARGET_W'($urandom_range(600, 1));
      endcase
      send_load(cur_seq, s, op, base, aim);
    end
    // close the route with a stop code unless it fills the sequence
    if (len < MAX_STEP) begin
      v  = $urandom_range(12);
      op = (v == 0) ? OP_W'(0) : OP_W'(v + 3);
      send_load(cur_seq, len, op, BASE_W'($urandom), TARGET_W'($urandom));
    end
    send_key(CMD_START);
    stuck = 0;
    for (int k = 0; k < 200 && run_on; k++) begin
      cover_steps();
      tgt = tbl_target[cur_seq][cur_step];
      case (quick ? 2 : $urandom_range(19))
        0: send_key(CMD_START);
        1: send_item(CMD_LOAD, random_item());
        default: begin
          // abort a step that can never complete
          if (tgt == 0 || tgt > FULL_MAG) begin
            if (stuck >= 3) send_key(CMD_NEXT);
            else route_tick(1'b0);
            stuck++;
          end else begin
            route_tick(quick || $urandom_range(2) == 0);
          end
        end
      endcase
    end
  endtask

  task automatic noise_burst();
    logic [CMD_W-1:0] cmd;
    repeat ($urandom_range(5, 1)) begin
      cmd = CMD_W'($urandom_range(3));
      if (cmd == CMD_TICK) cover_steps();
      send_item(cmd, random_item());
    end
  endtask

  // Wait until every queued result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEQ_COUNT:  cfg_count = val[COUNT_W-1:0];
      CFG_LEFT_GAIN:  cfg_lgain = val;
      CFG_RIGHT_GAIN: cfg_rgain = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int count, input int lgain, input int rgain);
    drain();
    // upper data bits of the count write are don't-care
    write_reg(CFG_SEQ_COUNT, {(CFG_DATA_W - COUNT_W)'($urandom), COUNT_W'(count)});
    write_reg(CFG_LEFT_GAIN, CFG_DATA_W'(lgain));
    write_reg(CFG_RIGHT_GAIN, CFG_DATA_W'(rgain));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Turns, over-limit drives, zero and full targets, stop codes, keys
  task automatic test_directed_cases();
    send_tick({24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000000});
    send_load(0, 0, OP_FWD, 1000, 100);
    send_load(0, 1, OP_LEFT, 2000, FULL_MAG);
    send_load(0, 2, OP_RIGHT, 4095, 0);
    send_load(0, 3, OP_W'(0), 4095, 24'hFFFFFF);
    send_key(CMD_START);
    send_tick({24'd50, 24'd0, 24'hFFFF9D, 24'd99});
    send_key(CMD_START);
    send_load(0, 0, OP_FWD, 3510, 100);
    send_tick({24'd1, 24'd2, 24'd3, 24'd4});
    send_tick({24'd3, 24'hFFFF9C, 24'd7, 24'd0});
    send_tick({24'h7FFFFF, 24'h800001, 24'h7FFFFF, 24'h800001});
    send_tick({24'h800000, 24'd0, 24'd0, 24'd0});
    send_tick({24'h800000, 24'h800000, 24'h800000, 24'h800000});
    send_key(CMD_NEXT);
    send_load(1, 0, OP_FWD, 500, 10);
    send_load(1, 1, OP_W'(8), 100, 10);
    send_key(CMD_START);
    send_tick({24'd0, 24'd0, 24'd10, 24'd0});
    send_load(1, 0, OP_W'(15), 4095, 1);
    send_key(CMD_START);
    send_tick({24'd0, 24'd0, 24'd0, 24'd0});
    send_key(CMD_NEXT);
  endtask

  // A route through every step of one sequence runs off the table end
  task automatic test_table_end();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    run_route(MAX_STEP, 1'b1);
  endtask

  // Random routes and noise under several register settings and pacings
  task automatic test_register_settings();
    int goal;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int k = 0; k < 2; k++) begin
        case (ph * 2 + k)
          0: apply_setting(SEQ_COUNT_RST, LEFT_GAIN_RST, RIGHT_GAIN_RST);
          1: apply_setting(8, 0, 8191);
          2: apply_setting(0, 8191, 0);
          3: apply_setting(15, 4096, 2048);
          4: apply_setting(1, 6144, 6145);
          5: apply_setting(8, $urandom_range(8191), $urandom_range(8191));
          6: apply_setting(3, 2047, 6143);
          default: apply_setting($urandom_range(15), $urandom_range(8191), $urandom_range(8191));
        endcase
        goal = items_sent + 60;
        while (items_sent < goal) begin
          case ($urandom_range(7))
            0: noise_burst();
            1: send_key(CMD_NEXT);
            default: run_route(($urandom_range(14) == 0) ? MAX_STEP : $urandom_range(6, 1), 1'b0);
          endcase
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest prediction; pace out_tready
  always @(posedge clk) begin : result_check
    route_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_outputs.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_outputs.pop_front();
        got  = route_result_t'(out_tdata[$bits(route_result_t)-1:0]);
        for (int i = 0; i < 4; i++)
          check_field($sformatf("drive_m%0d", i + 1), $signed(want.drive[i]),
                      $signed(got.drive[i]));
        check_field("brake", want.brake, got.brake);
        check_field("clear_counts", want.clear_counts, got.clear_counts);
        check_field("running", want.running, got.running);
        check_field("active_sequence", want.active_sequence, got.active_sequence);
        check_field("active_step", want.active_step, got.active_step);
        results_checked++;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_table_end();
    test_register_settings();
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, results_checked);
    $display("ran %0d routes under %0d register settings and four pacing modes",
             routes_run, settings_applied);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
